@@ sv/cbp_pkg.sv @@
// ---------------------------------------------------------------------------
// cbp_pkg
// types and helpers shared by the cylinder/box push-out pipeline
// ---------------------------------------------------------------------------
`default_nettype none
package cbp_pkg;

   localparam int unsigned SQRT_STEPS = 32;
   localparam int unsigned DIV_STEPS  = 32;

   typedef enum logic [1:0] {
      DIR_XP = 2'd0,
      DIR_XN = 2'd1,
      DIR_ZP = 2'd2,
      DIR_ZN = 2'd3
   } dir_type;

   // data that rides alongside the root and quotient stages
   typedef struct packed {
      logic signed [31:0] nx;
      logic signed [31:0] nz;
      logic [30:0]        adx;
      logic [30:0]        adz;
      logic [30:0]        r;
      logic               sx;
      logic               sz;
      logic               outside;
      logic               moved;
   } side_type;

   typedef struct packed {
      logic [63:0] x;
      logic [34:0] rem;
      logic [31:0] root;
      side_type    side;
   } sqrt_type;

   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] lo;
      logic [31:0] q;
   } div_lane_type;

   typedef struct packed {
      logic [32:0]  den;
      div_lane_type lx;
      div_lane_type lz;
      side_type     side;
   } div_type;

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] res;
      if (v > 35'sh0_7FFF_FFFF) begin
         res = 32'sh7FFF_FFFF;
      end else if (v < -35'sh0_8000_0000) begin
         res = 32'sh8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

   function automatic sqrt_type sqrt_step(input sqrt_type s);
      sqrt_type    o;
      logic [34:0] rem2;
      logic [34:0] trial;
      o     = s;
      rem2  = {s.rem[32:0], s.x[63:62]};
      trial = {1'b0, s.root, 2'b01};
      o.x   = {s.x[61:0], 2'b00};
      if (rem2 >= trial) begin
         o.rem  = rem2 - trial;
         o.root = {s.root[30:0], 1'b1};
      end else begin
         o.rem  = rem2;
         o.root = {s.root[30:0], 1'b0};
      end
      return o;
   endfunction

   function automatic div_lane_type div_step(input div_lane_type l, input logic [32:0] den);
      div_lane_type o;
      logic [33:0]  rem2;
      rem2 = {l.rem[32:0], l.lo[31]};
      o.lo = {l.lo[30:0], 1'b0};
      if (rem2 >= {1'b0, den}) begin
         o.rem = rem2 - {1'b0, den};
         o.q   = {l.q[30:0], 1'b1};
      end else begin
         o.rem = rem2;
         o.q   = {l.q[30:0], 1'b0};
      end
      return o;
   endfunction

endpackage
`default_nettype wire

@@ sv/cylinder_box_pushout.sv @@
// throughput: one beat per cycle; busy stays low, nothing ever waits
// depth is set by the 32-stage square root and the 32-stage divider,
// each retiring one result bit per stage
// reset: synchronous, active high; clears every stage valid bit
// ---------------------------------------------------------------------------
// cylinder_box_pushout
// pushes a vertical cylinder's centre out of an axis-aligned box
// ---------------------------------------------------------------------------
`default_nettype none
module cylinder_box_pushout
   import cbp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_box_min_x,
   input  wire logic signed [31:0] req_box_min_y,
   input  wire logic signed [31:0] req_box_min_z,
   input  wire logic signed [31:0] req_box_max_x,
   input  wire logic signed [31:0] req_box_max_y,
   input  wire logic signed [31:0] req_box_max_z,
   input  wire logic signed [31:0] req_centre_x,
   input  wire logic signed [31:0] req_centre_z,
   input  wire logic [30:0]        req_radius,
   input  wire logic signed [31:0] req_span_bottom,
   input  wire logic signed [31:0] req_span_top,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_new_centre_x,
   output logic signed [31:0]      rsp_new_centre_z,
   output logic                    rsp_moved
);

   // every stage takes a new beat each cycle
   assign busy = 1'b0;

   // ---- stage 0: input capture ----
   logic               s0_vld_ff;
   logic signed [31:0] s0_mnx_ff, s0_mny_ff, s0_mnz_ff;
   logic signed [31:0] s0_mxx_ff, s0_mxy_ff, s0_mxz_ff;
   logic signed [31:0] s0_cx_ff, s0_cz_ff, s0_y0_ff, s0_y1_ff;
   logic [30:0]        s0_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start & ~busy;
      end
      s0_mnx_ff <= req_box_min_x;
      s0_mny_ff <= req_box_min_y;
      s0_mnz_ff <= req_box_min_z;
      s0_mxx_ff <= req_box_max_x;
      s0_mxy_ff <= req_box_max_y;
      s0_mxz_ff <= req_box_max_z;
      s0_cx_ff  <= req_centre_x;
      s0_cz_ff  <= req_centre_z;
      s0_r_ff   <= req_radius;
      s0_y0_ff  <= req_span_bottom;
      s0_y1_ff  <= req_span_top;
   end

   // ---- stage 1: clamp, offsets, penetration depths ----
   logic signed [31:0] clx, clz;
   logic signed [32:0] dx, dz;
   logic [32:0]        adx_w, adz_w;
   logic               s1_vld_ff, s1_ovl_ff, s1_small_ff, s1_sx_ff, s1_sz_ff;
   logic [30:0]        s1_adx_ff, s1_adz_ff, s1_r_ff;
   logic signed [31:0] s1_cx_ff, s1_cz_ff;
   logic signed [32:0] s1_pxp_ff, s1_pxn_ff, s1_pzp_ff, s1_pzn_ff;

   always_comb begin
      // clamp exactly as written, so an inverted box is not reordered
      if (s0_cx_ff < s0_mnx_ff)       clx = s0_mnx_ff;
      else if (s0_cx_ff > s0_mxx_ff)  clx = s0_mxx_ff;
      else                            clx = s0_cx_ff;
      if (s0_cz_ff < s0_mnz_ff)       clz = s0_mnz_ff;
      else if (s0_cz_ff > s0_mxz_ff)  clz = s0_mxz_ff;
      else                            clz = s0_cz_ff;
      dx    = 33'(s0_cx_ff) - 33'(clx);
      dz    = 33'(s0_cz_ff) - 33'(clz);
      adx_w = dx[32] ? 33'(-dx) : 33'(dx);
      adz_w = dz[32] ? 33'(-dz) : 33'(dz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s0_vld_ff;
      end
      s1_ovl_ff   <= !((s0_y1_ff <= s0_mny_ff) || (s0_y0_ff >= s0_mxy_ff));
      s1_small_ff <= (adx_w < {2'b00, s0_r_ff}) && (adz_w < {2'b00, s0_r_ff});
      s1_adx_ff   <= adx_w[30:0];
      s1_adz_ff   <= adz_w[30:0];
      s1_sx_ff    <= dx[32];
      s1_sz_ff    <= dz[32];
      s1_r_ff     <= s0_r_ff;
      s1_cx_ff    <= s0_cx_ff;
      s1_cz_ff    <= s0_cz_ff;
      s1_pxp_ff   <= 33'(s0_mxx_ff) - 33'(s0_cx_ff);
      s1_pxn_ff   <= 33'(s0_cx_ff) - 33'(s0_mnx_ff);
      s1_pzp_ff   <= 33'(s0_mxz_ff) - 33'(s0_cz_ff);
      s1_pzn_ff   <= 33'(s0_cz_ff) - 33'(s0_mnz_ff);
   end

   // ---- stage 2: squares and shortest way out ----
   logic signed [32:0] m_a, m_b, m_w;
   dir_type            d_a, d_b, d_w;
   logic               s2_vld_ff, s2_near_ff, s2_sx_ff, s2_sz_ff;
   logic [61:0]        s2_sqx_ff, s2_sqz_ff, s2_r2_ff;
   logic [30:0]        s2_adx_ff, s2_adz_ff, s2_r_ff;
   logic signed [31:0] s2_cx_ff, s2_cz_ff;
   logic signed [32:0] s2_m_ff;
   dir_type            s2_dir_ff;

   always_comb begin
      // ties keep the earlier of +x, -x, +z, -z
      if (s1_pxn_ff < s1_pxp_ff) begin
         m_a = s1_pxn_ff; d_a = DIR_XN;
      end else begin
         m_a = s1_pxp_ff; d_a = DIR_XP;
      end
      if (s1_pzn_ff < s1_pzp_ff) begin
         m_b = s1_pzn_ff; d_b = DIR_ZN;
      end else begin
         m_b = s1_pzp_ff; d_b = DIR_ZP;
      end
      if (m_b < m_a) begin
         m_w = m_b; d_w = d_b;
      end else begin
         m_w = m_a; d_w = d_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_near_ff <= s1_ovl_ff & s1_small_ff;
      s2_sqx_ff  <= 62'(s1_adx_ff) * 62'(s1_adx_ff);
      s2_sqz_ff  <= 62'(s1_adz_ff) * 62'(s1_adz_ff);
      s2_r2_ff   <= 62'(s1_r_ff) * 62'(s1_r_ff);
      s2_adx_ff  <= s1_adx_ff;
      s2_adz_ff  <= s1_adz_ff;
      s2_sx_ff   <= s1_sx_ff;
      s2_sz_ff   <= s1_sz_ff;
      s2_r_ff    <= s1_r_ff;
      s2_cx_ff   <= s1_cx_ff;
      s2_cz_ff   <= s1_cz_ff;
      s2_m_ff    <= m_w;
      s2_dir_ff  <= d_w;
   end

   // ---- stage 3: distance test, inside case resolved here ----
   logic [62:0]        d2;
   logic               hit;
   logic signed [33:0] step_len;
   logic signed [34:0] ix_sum, iz_sum;
   sqrt_type           sq_first;

   always_comb begin
      d2       = 63'(s2_sqx_ff) + 63'(s2_sqz_ff);
      hit      = s2_near_ff && (d2 < 63'(s2_r2_ff));
      step_len = 34'(s2_m_ff) + 34'(s2_r_ff);
      ix_sum   = 35'(s2_cx_ff);
      iz_sum   = 35'(s2_cz_ff);
      if (hit && (d2 == '0)) begin
         unique case (s2_dir_ff)
            DIR_XP:  ix_sum = 35'(s2_cx_ff) + 35'(step_len);
            DIR_XN:  ix_sum = 35'(s2_cx_ff) - 35'(step_len);
            DIR_ZP:  iz_sum = 35'(s2_cz_ff) + 35'(step_len);
            DIR_ZN:  iz_sum = 35'(s2_cz_ff) - 35'(step_len);
            default: ix_sum = 35'(s2_cx_ff);
         endcase
      end
      sq_first.x            = {1'b0, d2};
      sq_first.rem          = '0;
      sq_first.root         = '0;
      sq_first.side.nx      = sat32(ix_sum);
      sq_first.side.nz      = sat32(iz_sum);
      sq_first.side.adx     = s2_adx_ff;
      sq_first.side.adz     = s2_adz_ff;
      sq_first.side.r       = s2_r_ff;
      sq_first.side.sx      = s2_sx_ff;
      sq_first.side.sz      = s2_sz_ff;
      sq_first.side.outside = hit && (d2 != '0);
      sq_first.side.moved   = hit;
   end

   // ---- root stages: one root bit per stage ----
   sqrt_type sq_ff  [0:SQRT_STEPS];
   logic     sq_vld_ff [0:SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else begin
         sq_vld_ff[0] <= s2_vld_ff;
      end
      sq_ff[0] <= sq_first;
   end

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[i+1] <= 1'b0;
         end else begin
            sq_vld_ff[i+1] <= sq_vld_ff[i];
         end
         sq_ff[i+1] <= sqrt_step(sq_ff[i]);
      end
   end

   // ---- product stage: offset times gap to the radius ----
   logic [30:0] gap;
   logic        mu_vld_ff;
   logic [61:0] mu_ax_ff, mu_az_ff;
   logic [30:0] mu_d_ff;
   side_type    mu_side_ff;

   assign gap = sq_ff[SQRT_STEPS].side.r - sq_ff[SQRT_STEPS].root[30:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_vld_ff <= 1'b0;
      end else begin
         mu_vld_ff <= sq_vld_ff[SQRT_STEPS];
      end
      mu_ax_ff   <= 62'(sq_ff[SQRT_STEPS].side.adx) * 62'(gap);
      mu_az_ff   <= 62'(sq_ff[SQRT_STEPS].side.adz) * 62'(gap);
      mu_d_ff    <= sq_ff[SQRT_STEPS].root[30:0];
      mu_side_ff <= sq_ff[SQRT_STEPS].side;
   end

   // ---- divider setup: (2a + d) / 2d, rounded half away from zero ----
   logic [63:0] num_x, num_z;
   div_type     dv_first;

   always_comb begin
      num_x            = {1'b0, mu_ax_ff, 1'b0} + 64'(mu_d_ff);
      num_z            = {1'b0, mu_az_ff, 1'b0} + 64'(mu_d_ff);
      dv_first.den     = {1'b0, mu_d_ff, 1'b0};
      // quotient fits 32 bits, so the high half starts below the divisor
      dv_first.lx.rem  = {2'b00, num_x[63:32]};
      dv_first.lx.lo   = num_x[31:0];
      dv_first.lx.q    = '0;
      dv_first.lz.rem  = {2'b00, num_z[63:32]};
      dv_first.lz.lo   = num_z[31:0];
      dv_first.lz.q    = '0;
      dv_first.side    = mu_side_ff;
   end

   div_type dv_ff     [0:DIV_STEPS];
   logic    dv_vld_ff [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else begin
         dv_vld_ff[0] <= mu_vld_ff;
      end
      dv_ff[0] <= dv_first;
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j+1] <= 1'b0;
         end else begin
            dv_vld_ff[j+1] <= dv_vld_ff[j];
         end
         dv_ff[j+1].den  <= dv_ff[j].den;
         dv_ff[j+1].lx   <= div_step(dv_ff[j].lx, dv_ff[j].den);
         dv_ff[j+1].lz   <= div_step(dv_ff[j].lz, dv_ff[j].den);
         dv_ff[j+1].side <= dv_ff[j].side;
      end
   end

   // ---- output stage: apply signed push and saturate ----
   side_type           last;
   logic signed [34:0] px, pz, ox, oz;
   logic               rsp_valid_ff, rsp_moved_ff;
   logic signed [31:0] rsp_x_ff, rsp_z_ff;

   always_comb begin
      last = dv_ff[DIV_STEPS].side;
      px   = last.sx ? -35'(dv_ff[DIV_STEPS].lx.q) : 35'(dv_ff[DIV_STEPS].lx.q);
      pz   = last.sz ? -35'(dv_ff[DIV_STEPS].lz.q) : 35'(dv_ff[DIV_STEPS].lz.q);
      ox   = 35'(last.nx);
      oz   = 35'(last.nz);
      if (last.outside) begin
         ox = 35'(last.nx) + px;
         oz = 35'(last.nz) + pz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_vld_ff[DIV_STEPS];
      end
      rsp_x_ff     <= sat32(ox);
      rsp_z_ff     <= sat32(oz);
      rsp_moved_ff <= last.moved;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_new_centre_x = rsp_x_ff;
   assign rsp_new_centre_z = rsp_z_ff;
   assign rsp_moved        = rsp_moved_ff;

endmodule
`default_nettype wire

@@ sv/cbp_checker.sv @@
// ---------------------------------------------------------------------------
// cbp_checker
// port-level checks on the push-out pipeline, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none
module cbp_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic signed [31:0] req_centre_x,
   input wire logic [30:0]        req_radius,
   input wire logic               rsp_valid,
   input wire logic signed [31:0] rsp_new_centre_x,
   input wire logic               rsp_moved
);

   localparam int unsigned LATENCY = 71;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result beat missing");

   a_zero_radius: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_radius == '0) |-> ##LATENCY !rsp_moved)
      else $error("zero radius moved");

   a_unmoved_keeps_x: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_moved) |-> rsp_new_centre_x == $past(req_centre_x, LATENCY))
      else $error("unmoved centre changed");

endmodule

bind cylinder_box_pushout cbp_checker u_cbp_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_centre_x     (req_centre_x),
   .req_radius       (req_radius),
   .rsp_valid        (rsp_valid),
   .rsp_new_centre_x (rsp_new_centre_x),
   .rsp_moved        (rsp_moved)
);
`default_nettype wire

@@ tb/sv/cbp_pushout_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cbp_pushout_checker
// watches the request and response ports, predicts each push-out result
// and compares it field by field with what the block returns
// ---------------------------------------------------------------------------
`default_nettype none
module cbp_pushout_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic signed [31:0] req_box_min_x,
   input  wire logic signed [31:0] req_box_min_y,
   input  wire logic signed [31:0] req_box_min_z,
   input  wire logic signed [31:0] req_box_max_x,
   input  wire logic signed [31:0] req_box_max_y,
   input  wire logic signed [31:0] req_box_max_z,
   input  wire logic signed [31:0] req_centre_x,
   input  wire logic signed [31:0] req_centre_z,
   input  wire logic [30:0]        req_radius,
   input  wire logic signed [31:0] req_span_bottom,
   input  wire logic signed [31:0] req_span_top,
   input  wire logic               rsp_valid,
   input  wire logic signed [31:0] rsp_new_centre_x,
   input  wire logic signed [31:0] rsp_new_centre_z,
   input  wire logic               rsp_moved,
   output int                      fail_count,
   output int                      pending,
   output int                      moved_count,
   output int                      inside_count
);

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cz;
      logic               moved;
      logic               from_box;
   } pushout_type;

   pushout_type expected_q[$];

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned acc, probe, x;
      acc   = 0;
      x     = v;
      probe = 64'd1 << 62;
      while (probe > x) probe = probe >> 2;
      while (probe != 0) begin
         if (x >= acc + probe) begin
            x   = x - (acc + probe);
            acc = (acc >> 1) + probe;
         end else begin
            acc = acc >> 1;
         end
         probe = probe >> 2;
      end
      return acc;
   endfunction

   // delta * gap / dlen, rounded to nearest, ties away from zero
   function automatic longint scaled_push(input longint delta, input longint unsigned gap,
                                          input longint unsigned dlen);
      longint unsigned mag, q;
      mag = (delta < 0) ? longint'(-delta) : longint'(delta);
      q   = (2 * (mag * gap) + dlen) / (2 * dlen);
      return (delta < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp_axis(input longint c, input longint lo, input longint hi);
      if (c < lo) return lo;
      if (c > hi) return hi;
      return c;
   endfunction

   function automatic pushout_type predict_pushout();
      pushout_type     res;
      longint          mnx, mny, mnz, mxx, mxy, mxz, cx, cz, r, y0, y1;
      longint          dx, dz, adx, adz, nx, nz, pen, best;
      longint unsigned d2, dlen;
      cbp_pkg::dir_type side;
      mnx = req_box_min_x;  mny = req_box_min_y;  mnz = req_box_min_z;
      mxx = req_box_max_x;  mxy = req_box_max_y;  mxz = req_box_max_z;
      cx  = req_centre_x;   cz  = req_centre_z;   r   = longint'({1'b0, req_radius});
      y0  = req_span_bottom; y1 = req_span_top;
      nx  = cx;
      nz  = cz;
      res = '0;
      if (!(y1 <= mny || y0 >= mxy)) begin
         dx  = cx - clamp_axis(cx, mnx, mxx);
         dz  = cz - clamp_axis(cz, mnz, mxz);
         adx = dx < 0 ? -dx : dx;
         adz = dz < 0 ? -dz : dz;
         if (adx < r && adz < r) begin
            d2 = longint'(adx * adx) + longint'(adz * adz);
            if (d2 < longint'(r * r)) begin
               res.moved = 1'b1;
               if (d2 != 0) begin
                  dlen = floor_root(d2);
                  nx   = cx + scaled_push(dx, r - dlen, dlen);
                  nz   = cz + scaled_push(dz, r - dlen, dlen);
               end else begin
                  // centre inside: leave through the nearest face, +x -x +z -z on ties
                  res.from_box = 1'b1;
                  best = mxx - cx;
                  side = cbp_pkg::DIR_XP;
                  pen  = cx - mnx;
                  if (pen < best) begin best = pen; side = cbp_pkg::DIR_XN; end
                  pen  = mxz - cz;
                  if (pen < best) begin best = pen; side = cbp_pkg::DIR_ZP; end
                  pen  = cz - mnz;
                  if (pen < best) begin best = pen; side = cbp_pkg::DIR_ZN; end
                  case (side)
                     cbp_pkg::DIR_XP: nx = cx + (best + r);
                     cbp_pkg::DIR_XN: nx = cx - (best + r);
                     cbp_pkg::DIR_ZP: nz = cz + (best + r);
                     default:         nz = cz - (best + r);
                  endcase
               end
            end
         end
      end
      res.cx = clip32(nx);
      res.cz = clip32(nz);
      return res;
   endfunction

   always @(posedge clock) begin
      pushout_type exp_beat;
      if (reset) begin
         expected_q.delete();
         fail_count   <= 0;
         moved_count  <= 0;
         inside_count <= 0;
         pending      <= 0;
      end else begin
         if (start && !busy) expected_q.push_back(predict_pushout());
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $error("response beat with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               exp_beat = expected_q.pop_front();
               if (exp_beat.moved) moved_count <= moved_count + 1;
               if (exp_beat.from_box) inside_count <= inside_count + 1;
               if (rsp_new_centre_x !== exp_beat.cx || rsp_new_centre_z !== exp_beat.cz ||
                   rsp_moved !== exp_beat.moved) begin
                  fail_count <= fail_count + 1;
                  if (rsp_new_centre_x !== exp_beat.cx)
                     $error("new_centre_x expected %0d got %0d", exp_beat.cx, rsp_new_centre_x);
                  if (rsp_new_centre_z !== exp_beat.cz)
                     $error("new_centre_z expected %0d got %0d", exp_beat.cz, rsp_new_centre_z);
                  if (rsp_moved !== exp_beat.moved)
                     $error("moved expected %0b got %0b", exp_beat.moved, rsp_moved);
               end
            end
         end
         pending <= expected_q.size();
      end
   end

endmodule
`default_nettype wire

@@ tb/sv/tb_cylinder_box_pushout.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_cylinder_box_pushout
// drives directed and random cylinder/box beats with random gaps into the
// push-out pipeline; the checker beside it predicts and compares results
// ---------------------------------------------------------------------------
`default_nettype none
module tb_cylinder_box_pushout;

   localparam int RANDOM_BEATS = 1400;
   localparam int LATENCY      = 71;
   localparam int IDLE_LIMIT   = 4000;  // far above latency plus the longest gap

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [31:0] req_box_min_x = '0, req_box_min_y = '0, req_box_min_z = '0;
   logic signed [31:0] req_box_max_x = '0, req_box_max_y = '0, req_box_max_z = '0;
   logic signed [31:0] req_centre_x = '0, req_centre_z = '0;
   logic [30:0]        req_radius = '0;
   logic signed [31:0] req_span_bottom = '0, req_span_top = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_new_centre_x, rsp_new_centre_z;
   logic               rsp_moved;
   int                 fail_count, pending, moved_count, inside_count;
   int                 beats_sent = 0;
   int                 idle_cycles = 0;

   always #2 clock = ~clock;

   cylinder_box_pushout u_dut (.*);

   cbp_pushout_checker u_checker (.*);

   // watchdog: any accepted beat on either side resets the idle count
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // present one beat at the falling edge and hold it until it is taken
   // the radius comes in 32 bits wide and only its low 31 bits are driven
   task automatic send_beat(input logic signed [31:0] mnx, mny, mnz, mxx, mxy, mxz,
                            input logic signed [31:0] cx, cz,
                            input logic [31:0] rad,
                            input logic signed [31:0] bot, top);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_box_min_x = mnx;  req_box_min_y = mny;  req_box_min_z = mnz;
      req_box_max_x = mxx;  req_box_max_y = mxy;  req_box_max_z = mxz;
      req_centre_x  = cx;   req_centre_z  = cz;   req_radius    = rad[30:0];
      req_span_bottom = bot; req_span_top = top;
      start = 1'b1;
      do @(posedge clock); while (busy);
      beats_sent++;
      @(negedge clock);
   endtask

   localparam logic signed [31:0] ONE  = 32'sh0001_0000;
   localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SMIN = 32'sh8000_0000;
   localparam logic [31:0]        RMAX = 32'h7FFF_FFFF;

   initial begin
      logic signed [31:0] mnx, mny, mnz, mxx, mxy, mxz, cx, cz, bot, top, wx, wz;
      logic [31:0]        rad;
      int                 shape;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed beats: box [0,4] in x and z, y [0,4]
      // no vertical overlap, from above and from below
      send_beat(0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 5*ONE, 2*ONE, ONE, 4*ONE, 6*ONE);
      send_beat(0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 5*ONE, 2*ONE, ONE, -ONE, 0);
      // zero radius, centre inside
      send_beat(0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 2*ONE, 2*ONE, 0, ONE, 2*ONE);
      // inside pushes toward each face, then a four-way tie
      send_beat(0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 3*ONE, 2*ONE, ONE, ONE, 2*ONE);
      send_beat(0, 0, 0, 4*ONE, 4*ONE, 4*ONE, ONE, 2*ONE, ONE, ONE, 2*ONE);
      send_beat(0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 2*ONE, 3*ONE, ONE, ONE, 2*ONE);
      send_beat(0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 2*ONE, ONE, ONE, ONE, 2*ONE);
      send_beat(0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 2*ONE, 2*ONE, ONE, ONE, 2*ONE);
      // outside: side contact, corner contact, just touching, tiny push
      send_beat(0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 4*ONE + ONE/2, 2*ONE, ONE, ONE, 2*ONE);
      send_beat(0, 0, 0, 4*ONE, 4*ONE, 4*ONE, -ONE/2, -ONE/2, ONE, ONE, 2*ONE);
      send_beat(0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 5*ONE, 2*ONE, ONE, ONE, 2*ONE);
      send_beat(0, 0, 0, 4*ONE, 4*ONE, 4*ONE, 4*ONE + ONE - 1, 2*ONE, ONE, ONE, 2*ONE);
      send_beat(0, 0, 0, 4*ONE, 4*ONE, 4*ONE, -3, -3, 5, ONE, 2*ONE);
      // inverted boxes
      send_beat(4*ONE, 0, 0, 0, 4*ONE, 4*ONE, 2*ONE, 2*ONE, 3*ONE, ONE, 2*ONE);
      send_beat(0, 0, 4*ONE, 4*ONE, 4*ONE, 0, 2*ONE, 2*ONE, 3*ONE, ONE, 2*ONE);
      // extremes and saturation
      send_beat(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, 0, 0, RMAX, SMIN, SMAX);
      send_beat(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, SMAX - 5, 0, RMAX, 0, 1);
      send_beat(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, 0, SMIN + 5, RMAX, 0, 1);
      send_beat(0, SMIN, 0, SMAX, SMAX, SMAX, SMIN, SMIN, RMAX, SMIN, SMAX);
      send_beat(SMIN, SMIN, SMIN, 0, SMAX, 0, SMAX, SMAX, RMAX, SMIN, SMAX);
      send_beat(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMIN, SMAX, RMAX, SMIN, SMAX);

      // hold off until the pipeline has drained
      start = 1'b0;
      wait (pending == 0);
      @(negedge clock);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         shape = $urandom_range(0, 9);
         if (shape == 0) begin
            // raw noise across the full field ranges
            mnx = $urandom; mny = $urandom; mnz = $urandom;
            mxx = $urandom; mxy = $urandom; mxz = $urandom;
            cx = $urandom; cz = $urandom; rad = $urandom;
            bot = $urandom; top = $urandom;
         end else begin
            // box near the origin or far out, centre around it within reach
            mnx = $urandom; mnz = $urandom; mny = $urandom;
            if (shape < 8) begin
               mnx = mnx >>> $urandom_range(8, 31);
               mnz = mnz >>> $urandom_range(8, 31);
               mny = mny >>> 8;
            end
            wx  = $urandom_range(0, 32'h0008_0000);
            wz  = $urandom_range(0, 32'h0008_0000);
            mxx = mnx + wx;
            mxz = mnz + wz;
            mxy = mny + ($urandom_range(0, 32'h0008_0000));
            rad = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000);
            cx  = mnx - 32'sh0004_0000 + $signed($urandom_range(0, 32'h0010_0000));
            cz  = mnz - 32'sh0004_0000 + $signed($urandom_range(0, 32'h0010_0000));
            bot = mny - $signed($urandom_range(0, 32'h0004_0000));
            top = bot + $signed($urandom_range(0, 32'h000C_0000));
            if (shape == 9) begin
               // swap some bounds to get inverted boxes
               {mnx, mxx} = {mxx, mnx};
               if ($urandom_range(0, 1)) {mnz, mxz} = {mxz, mnz};
            end
         end
         send_beat(mnx, mny, mnz, mxx, mxy, mxz, cx, cz, rad, bot, top);
      end

      start = 1'b0;
      wait (pending == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("%0d beats sent: %0d results pushed out, %0d of them from inside the box",
               beats_sent, moved_count, inside_count);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d failing results", fail_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire
